@@ rtl/srt_pkg.sv @@
// Shared types and constants for the sensor reading table.
package srt_pkg;

    localparam int MODE_W  = 3;
    localparam int KEY_W   = 64;
    localparam int RAW_W   = 16;
    localparam int WHOLE_W = 12;
    localparam int FRAC_W  = 7;
    localparam int QUERY_W = 4;
    localparam int SLOTO_W = 4;
    localparam int LIVEO_W = 4;
    localparam int MISS_W  = 8;

    localparam logic [MODE_W-1:0] MODE_BUS  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_EXT  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TICK = 3'd2;
    localparam logic [MODE_W-1:0] MODE_OSET = 3'd3;
    localparam logic [MODE_W-1:0] MODE_OCLR = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ = 3'd5;

    localparam logic [MISS_W-1:0] MISS_CAP       = 8'd250;
    localparam logic [MISS_W-1:0] MISS_LIMIT_RST = 8'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic ready;
        logic lookup;
        logic update;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic accept;
        logic out_free;
    } sts_t;

endpackage

@@ rtl/srt_intf.sv @@
// Reading and result channel interfaces.
interface srt_in_if import srt_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [MODE_W-1:0]         mode;
    logic [KEY_W-1:0]          sensor_key;
    logic signed [RAW_W-1:0]   raw_reading;
    logic signed [WHOLE_W-1:0] whole_value;
    logic [FRAC_W-1:0]         hundredths;
    logic [QUERY_W-1:0]        slot_query;

    modport source (
        output valid, mode, sensor_key, raw_reading, whole_value, hundredths, slot_query,
        input  ready
    );
    modport sink (
        input  valid, mode, sensor_key, raw_reading, whole_value, hundredths, slot_query,
        output ready
    );
endinterface

interface srt_out_if import srt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [SLOTO_W-1:0] slot;
    logic               slot_found;
    logic [LIVEO_W-1:0] live_count;
    logic               entry_set;
    logic               entry_override;
    logic               entry_negative;
    logic [WHOLE_W-1:0] entry_whole;
    logic [FRAC_W-1:0]  entry_hundredths;
    logic [MISS_W-1:0]  entry_missed;

    modport source (
        output valid, slot, slot_found, live_count, entry_set, entry_override,
               entry_negative, entry_whole, entry_hundredths, entry_missed,
        input  ready
    );
    modport sink (
        input  valid, slot, slot_found, live_count, entry_set, entry_override,
               entry_negative, entry_whole, entry_hundredths, entry_missed,
        output ready
    );
endinterface

@@ rtl/srt_ctrl.sv @@
// Sequencer for the table: accept, lookup, update, emit.
module srt_ctrl import srt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sts.accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:   cmd.ready  = 1'b1;
            ST_LOOKUP: cmd.lookup = 1'b1;
            ST_UPDATE: cmd.update = 1'b1;
            ST_EMIT:   cmd.emit   = sts.out_free;
            default:   cmd        = '0;
        endcase
    end

endmodule

@@ rtl/srt_datapath.sv @@
// Slot storage, key match, claim and update logic, and the result register.
module srt_datapath import srt_pkg::*;
#(
    parameter int TABLE_SLOTS = 16,
    parameter int BUS_SLOTS   = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [MISS_W-1:0] cfg_wdata,
    srt_in_if.sink            reading,
    srt_out_if.source         result,
    input  cmd_t              cmd,
    output sts_t              sts
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int NBUS   = (BUS_SLOTS < TABLE_SLOTS) ? BUS_SLOTS : TABLE_SLOTS;
    localparam int LIVE_W = $clog2(NBUS + 1);

    // captured beat
    logic [MODE_W-1:0]  mode_reg;
    logic [KEY_W-1:0]   key_reg;
    logic               val_neg_reg;
    logic [WHOLE_W-1:0] val_mag_reg;
    logic [FRAC_W-1:0]  val_frac_reg;
    logic [QUERY_W-1:0] query_reg;

    // slot state
    logic [KEY_W-1:0]   slot_key_reg  [TABLE_SLOTS];
    logic               key_valid_reg [TABLE_SLOTS];
    logic               value_set_reg [TABLE_SLOTS];
    logic               forced_reg    [TABLE_SLOTS];
    logic               negative_reg  [TABLE_SLOTS];
    logic [WHOLE_W-1:0] whole_reg     [TABLE_SLOTS];
    logic [FRAC_W-1:0]  frac_reg      [TABLE_SLOTS];
    logic [MISS_W-1:0]  miss_reg      [TABLE_SLOTS];
    logic [MISS_W-1:0]  miss_limit_reg;

    logic [TABLE_SLOTS-1:0] match_reg;
    logic [TABLE_SLOTS-1:0] free_reg;
    logic [SLOT_W-1:0]      sel_reg;
    logic                   found_reg;

    logic               out_valid_reg;
    logic [SLOTO_W-1:0] out_slot_reg;
    logic               out_found_reg;
    logic [LIVEO_W-1:0] out_live_reg;
    logic               out_set_reg;
    logic               out_ovr_reg;
    logic               out_neg_reg;
    logic [WHOLE_W-1:0] out_whole_reg;
    logic [FRAC_W-1:0]  out_frac_reg;
    logic [MISS_W-1:0]  out_miss_reg;

    // input conversion
    logic [RAW_W-1:0]   raw_u;
    logic [RAW_W-1:0]   raw_mag;
    logic [WHOLE_W-1:0] bus_whole;
    logic [10:0]        frac_prod;
    logic [WHOLE_W-1:0] ext_w;
    logic [WHOLE_W-1:0] ext_mag;
    logic               accept;

    assign raw_u     = reading.raw_reading;
    assign raw_mag   = raw_u[RAW_W-1] ? (~raw_u + 16'd1) : raw_u;
    assign bus_whole = raw_mag[RAW_W-1:4];
    assign frac_prod = {7'd0, raw_mag[3:0]} * 11'd100;
    assign ext_w     = reading.whole_value;
    assign ext_mag   = ext_w[WHOLE_W-1] ? (12'd0 - ext_w) : ext_w;

    assign accept        = reading.valid && cmd.ready;
    assign reading.ready = cmd.ready;
    assign sts.accept    = accept;
    assign sts.out_free  = !out_valid_reg || result.ready;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= reading.mode;
            key_reg   <= reading.sensor_key;
            query_reg <= reading.slot_query;
            if (reading.mode == MODE_BUS)
            begin
                // readings between -1 and 0 store as positive
                val_neg_reg  <= raw_u[RAW_W-1] && (bus_whole != '0);
                val_mag_reg  <= bus_whole;
                val_frac_reg <= frac_prod[10:4];
            end
            else
            begin
                val_neg_reg  <= ext_w[WHOLE_W-1];
                val_mag_reg  <= ext_mag;
                val_frac_reg <= reading.hundredths;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            miss_limit_reg <= MISS_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            miss_limit_reg <= cfg_wdata;
        end
    end

    // parallel key compare and free-slot scan, registered
    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                match_reg[i] <= key_valid_reg[i] && (slot_key_reg[i] == key_reg);
                free_reg[i]  <= !value_set_reg[i] && ((mode_reg == MODE_BUS) || (i >= BUS_SLOTS));
            end
        end
    end

    // lowest-index pick
    logic              hit_any;
    logic [SLOT_W-1:0] hit_idx;
    logic              free_any;
    logic [SLOT_W-1:0] free_idx;

    always_comb
    begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                hit_any = 1'b1;
                hit_idx = SLOT_W'(i);
            end
            if (free_reg[i])
            begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    logic [SLOT_W+QUERY_W-1:0] query_ext;
    logic [SLOT_W-1:0]         upd_idx;
    logic                      upd_found;
    logic                      do_claim;
    logic                      do_reading;
    logic                      do_force;
    logic                      do_unforce;
    logic                      do_tick;

    assign query_ext = {{SLOT_W{1'b0}}, query_reg};

    always_comb
    begin
        upd_idx    = '0;
        upd_found  = 1'b0;
        do_claim   = 1'b0;
        do_reading = 1'b0;
        do_force   = 1'b0;
        do_unforce = 1'b0;
        do_tick    = 1'b0;
        case (mode_reg)
            MODE_BUS, MODE_EXT:
            begin
                if (hit_any)
                begin
                    upd_idx    = hit_idx;
                    upd_found  = 1'b1;
                    do_reading = 1'b1;
                end
                else if (free_any)
                begin
                    upd_idx    = free_idx;
                    upd_found  = 1'b1;
                    do_claim   = 1'b1;
                    do_reading = 1'b1;
                end
            end
            MODE_TICK: do_tick = 1'b1;
            MODE_OSET:
            begin
                upd_idx   = hit_idx;
                upd_found = hit_any;
                do_force  = hit_any;
            end
            MODE_OCLR:
            begin
                upd_idx    = hit_idx;
                upd_found  = hit_any;
                do_unforce = hit_any;
            end
            MODE_READ:
            begin
                if ({28'd0, query_reg} < 32'(TABLE_SLOTS))
                begin
                    upd_idx   = query_ext[SLOT_W-1:0];
                    upd_found = 1'b1;
                end
            end
            default: upd_found = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            sel_reg   <= upd_idx;
            found_reg <= upd_found;
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                if (do_claim && (upd_idx == SLOT_W'(i)))
                begin
                    slot_key_reg[i] <= key_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                key_valid_reg[i] <= 1'b0;
                value_set_reg[i] <= 1'b0;
                forced_reg[i]    <= 1'b0;
                negative_reg[i]  <= 1'b0;
                whole_reg[i]     <= '0;
                frac_reg[i]      <= '0;
                miss_reg[i]      <= '0;
            end
        end
        else if (cmd.update)
        begin
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                if (do_tick && (i < NBUS) && (miss_reg[i] < MISS_CAP))
                begin
                    miss_reg[i] <= miss_reg[i] + 8'd1;
                end
                if (upd_idx == SLOT_W'(i))
                begin
                    if (do_claim)
                    begin
                        key_valid_reg[i] <= 1'b1;
                    end
                    if (do_reading)
                    begin
                        value_set_reg[i] <= 1'b1;
                        // an overridden slot keeps its value and miss count
                        if (!forced_reg[i])
                        begin
                            negative_reg[i] <= val_neg_reg;
                            whole_reg[i]    <= val_mag_reg;
                            frac_reg[i]     <= val_frac_reg;
                            miss_reg[i]     <= '0;
                        end
                    end
                    if (do_force)
                    begin
                        value_set_reg[i] <= 1'b1;
                        forced_reg[i]    <= 1'b1;
                        negative_reg[i]  <= val_neg_reg;
                        whole_reg[i]     <= val_mag_reg;
                        frac_reg[i]      <= val_frac_reg;
                    end
                    if (do_unforce)
                    begin
                        value_set_reg[i] <= 1'b0;
                        forced_reg[i]    <= 1'b0;
                    end
                end
            end
        end
    end

    // live bus slots after the update
    logic [LIVE_W-1:0]         live_cnt;
    logic [LIVE_W+LIVEO_W-1:0] live_ext;
    logic [SLOT_W+SLOTO_W-1:0] slot_ext;

    always_comb
    begin
        live_cnt = '0;
        for (int i = 0; i < NBUS; i++)
        begin
            if (value_set_reg[i] && (miss_reg[i] < miss_limit_reg))
            begin
                live_cnt = live_cnt + LIVE_W'(1);
            end
        end
    end

    assign live_ext = {{LIVEO_W{1'b0}}, live_cnt};
    assign slot_ext = {{SLOTO_W{1'b0}}, sel_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_live_reg  <= live_ext[LIVEO_W-1:0];
            out_found_reg <= found_reg;
            if (found_reg)
            begin
                out_slot_reg  <= slot_ext[SLOTO_W-1:0];
                out_set_reg   <= value_set_reg[sel_reg];
                out_ovr_reg   <= forced_reg[sel_reg];
                out_neg_reg   <= negative_reg[sel_reg];
                out_whole_reg <= whole_reg[sel_reg];
                out_frac_reg  <= frac_reg[sel_reg];
                out_miss_reg  <= miss_reg[sel_reg];
            end
            else
            begin
                out_slot_reg  <= '0;
                out_set_reg   <= 1'b0;
                out_ovr_reg   <= 1'b0;
                out_neg_reg   <= 1'b0;
                out_whole_reg <= '0;
                out_frac_reg  <= '0;
                out_miss_reg  <= '0;
            end
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.slot             = out_slot_reg;
    assign result.slot_found       = out_found_reg;
    assign result.live_count       = out_live_reg;
    assign result.entry_set        = out_set_reg;
    assign result.entry_override   = out_ovr_reg;
    assign result.entry_negative   = out_neg_reg;
    assign result.entry_whole      = out_whole_reg;
    assign result.entry_hundredths = out_frac_reg;
    assign result.entry_missed     = out_miss_reg;

endmodule

@@ rtl/sensor_reading_table.sv @@
// Top level of the sensor reading table.
//
// A beat on the reading channel carries one command (bus reading, external
// reading, scan tick, override set, override clear or entry read) with a
// 64-bit sensor key and its value fields. Every command gives exactly one
// beat on the result channel: the slot touched, its entry after the update
// and the count of live bus slots.
// The miss limit register is written through cfg_wdata/cfg_we; the user must
// write it only while idle, as the block itself does not enforce this. A
// reading beat is taken in the idle step, then come key compare over all slots,
// slot pick and update, and the load of the result register; the sequencer
// handles one command at a time.
// The result register holds its beat while the receiver stalls; the next
// reading can be taken meanwhile, and the sequencer waits in its emit step
// only if the previous result is still unclaimed.
// Reset clears all slot state and the result valid and sets the miss limit
// to 5. Stored keys are not cleared; only key-valid slots take part in a match.
module sensor_reading_table import srt_pkg::*;
#(
    parameter int TABLE_SLOTS = 16,
    parameter int BUS_SLOTS   = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [MISS_W-1:0] cfg_wdata,
    srt_in_if.sink            reading,
    srt_out_if.source         result
);

    cmd_t cmd;
    sts_t sts;

    srt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    srt_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .BUS_SLOTS   (BUS_SLOTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .reading   (reading),
        .result    (result),
        .cmd       (cmd),
        .sts       (sts)
    );

    // one command in flight: no new beat right after one is taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        reading.valid && reading.ready |=> !reading.ready)
        else $error("reading taken while a command is in flight");

    // a result beat appears only from an emit step
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(cmd.emit))
        else $error("result valid without emit");

    // entries of a miss report as empty
    a_miss_empty: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.slot_found |->
            !result.entry_set && (result.entry_missed == '0) && (result.entry_whole == '0))
        else $error("entry fields set on a miss");

endmodule

@@ dv/sensor_reading_table_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for sensor_reading_table: directed and random tests against a table model.
module sensor_reading_table_tb;
    import srt_pkg::*;

    localparam int SLOTS         = 16;
    localparam int BUS_N         = 8;
    localparam int POOL_N        = 20;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 8;

    // codes the block ignores
    localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

    localparam logic [KEY_W-1:0] KEY_ONES = '1;
    localparam logic [KEY_W-1:0] KEY_ZERO = '0;
    localparam logic [KEY_W-1:0] KEY_A    = 64'hA5A5_5A5A_0123_4567;
    localparam logic [KEY_W-1:0] KEY_B    = 64'h8000_0000_0000_0001;
    localparam logic [KEY_W-1:0] KEY_E    = 64'h0F0F_F0F0_3C3C_C3C3;
    localparam logic [KEY_W-1:0] KEY_F    = 64'h7FFF_FFFF_FFFF_FFFE;
    localparam logic [KEY_W-1:0] KEY_G    = 64'h5555_AAAA_5555_AAAA;
    localparam logic [KEY_W-1:0] KEY_N    = 64'h0000_0001_0000_0000;
    localparam logic [KEY_W-1:0] KEY_GONE = 64'hDEAD_0000_BEEF_0000;
    localparam logic [KEY_W-1:0] KEY_SAT  = 64'h2468_ACE0_1357_9BDF;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [KEY_W-1:0]   key;
        logic [RAW_W-1:0]   raw;
        logic [WHOLE_W-1:0] whole;
        logic [FRAC_W-1:0]  hund;
        logic [QUERY_W-1:0] query;
    } reading_t;

    typedef struct packed {
        logic [SLOTO_W-1:0] slot;
        logic               found;
        logic [LIVEO_W-1:0] live;
        logic               has_val;
        logic               pinned;
        logic               neg;
        logic [WHOLE_W-1:0] whole;
        logic [FRAC_W-1:0]  hund;
        logic [MISS_W-1:0]  missed;
    } slot_report_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [MISS_W-1:0] cfg_wdata;

    srt_in_if  rd_if ();
    srt_out_if res_if ();

    sensor_reading_table #(
        .TABLE_SLOTS(SLOTS),
        .BUS_SLOTS  (BUS_N)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .reading  (rd_if),
        .result   (res_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // table model
    logic [KEY_W-1:0]   tbl_key     [SLOTS];
    logic               tbl_key_ok  [SLOTS];
    logic               tbl_has_val [SLOTS];
    logic               tbl_pinned  [SLOTS];
    logic               tbl_neg     [SLOTS];
    logic [WHOLE_W-1:0] tbl_whole   [SLOTS];
    logic [FRAC_W-1:0]  tbl_hund    [SLOTS];
    logic [MISS_W-1:0]  tbl_misses  [SLOTS];
    logic [MISS_W-1:0]  live_limit;

    slot_report_t     pending_results [$];
    logic [KEY_W-1:0] key_pool [POOL_N];

    bit steady = 1'b0;
    int errors = 0;
    int mismatches = 0;
    int n_items = 0;
    int n_results = 0;
    int n_limit_writes = 0;
    int full_hits = 0;
    int sat_hits = 0;
    int mode_hits [8] = '{default: 0};
    int cycle_count = 0;

    function automatic void reset_model();
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_key[i]     = '0;
            tbl_key_ok[i]  = 1'b0;
            tbl_has_val[i] = 1'b0;
            tbl_pinned[i]  = 1'b0;
            tbl_neg[i]     = 1'b0;
            tbl_whole[i]   = '0;
            tbl_hund[i]    = '0;
            tbl_misses[i]  = '0;
        end
        live_limit = MISS_LIMIT_RST;
    endfunction

    function automatic int find_slot(input logic [KEY_W-1:0] k);
        for (int i = 0; i < SLOTS; i++)
            if (tbl_key_ok[i] && tbl_key[i] == k)
                return i;
        return -1;
    endfunction

    // existing key first, else the first slot without a value from start
    function automatic int claim_slot(input logic [KEY_W-1:0] k, input int start);
        int hit;
        hit = find_slot(k);
        if (hit >= 0)
            return hit;
        for (int i = start; i < SLOTS; i++)
        begin
            if (!tbl_has_val[i])
            begin
                tbl_key[i]    = k;
                tbl_key_ok[i] = 1'b1;
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void store_temp(input int s, input logic n, input logic [WHOLE_W-1:0] mag,
                                       input logic [FRAC_W-1:0] frac);
        tbl_neg[s]   = n;
        tbl_whole[s] = mag;
        tbl_hund[s]  = frac;
    endfunction

    // pinned slots only get their set flag back
    function automatic void take_reading(input int s, input logic n, input logic [WHOLE_W-1:0] mag,
                                         input logic [FRAC_W-1:0] frac);
        tbl_has_val[s] = 1'b1;
        if (!tbl_pinned[s])
        begin
            store_temp(s, n, mag, frac);
            tbl_misses[s] = '0;
        end
    endfunction

    function automatic slot_report_t next_table_result(input reading_t r);
        slot_report_t       rep;
        int                 s;
        int                 live;
        logic [RAW_W-1:0]   m;
        logic [WHOLE_W-1:0] mag;
        logic [FRAC_W-1:0]  frac;
        s = -1;
        live = 0;
        case (r.mode)
            MODE_BUS:
            begin
                m = r.raw[RAW_W-1] ? (~r.raw + 16'd1) : r.raw;
                mag = m[RAW_W-1:4];
                frac = FRAC_W'((int'(m[3:0]) * 100) / 16);
                s = claim_slot(r.key, 0);
                // small negatives round to +0.xx
                if (s >= 0)
                    take_reading(s, r.raw[RAW_W-1] && mag != 0, mag, frac);
            end
            MODE_EXT:
            begin
                mag = r.whole[WHOLE_W-1] ? (~r.whole + 12'd1) : r.whole;
                s = claim_slot(r.key, BUS_N);
                if (s >= 0)
                    take_reading(s, r.whole[WHOLE_W-1], mag, r.hund);
            end
            MODE_TICK:
            begin
                for (int i = 0; i < BUS_N; i++)
                    if (tbl_misses[i] < MISS_CAP)
                        tbl_misses[i] = tbl_misses[i] + 8'd1;
            end
            MODE_OSET:
            begin
                s = find_slot(r.key);
                if (s >= 0)
                begin
                    mag = r.whole[WHOLE_W-1] ? (~r.whole + 12'd1) : r.whole;
                    tbl_has_val[s] = 1'b1;
                    tbl_pinned[s]  = 1'b1;
                    store_temp(s, r.whole[WHOLE_W-1], mag, r.hund);
                end
            end
            MODE_OCLR:
            begin
                s = find_slot(r.key);
                if (s >= 0)
                begin
                    tbl_has_val[s] = 1'b0;
                    tbl_pinned[s]  = 1'b0;
                end
            end
            MODE_READ:
                s = int'(r.query);
            default: ;
        endcase
        for (int i = 0; i < BUS_N; i++)
            if (tbl_has_val[i] && tbl_misses[i] < live_limit)
                live++;
        rep = '0;
        rep.live = LIVEO_W'(live);
        if (s >= 0)
        begin
            rep.slot    = SLOTO_W'(s);
            rep.found   = 1'b1;
            rep.has_val = tbl_has_val[s];
            rep.pinned  = tbl_pinned[s];
            rep.neg     = tbl_neg[s];
            rep.whole   = tbl_whole[s];
            rep.hund    = tbl_hund[s];
            rep.missed  = tbl_misses[s];
        end
        return rep;
    endfunction

    function automatic string show(input slot_report_t p);
        return $sformatf("slot=%0d found=%0b live=%0d set=%0b ovr=%0b neg=%0b whole=%0d hund=%0d miss=%0d",
                         p.slot, p.found, p.live, p.has_val, p.pinned, p.neg, p.whole, p.hund,
                         p.missed);
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic reading_t make_reading(input logic [MODE_W-1:0] m, input logic [KEY_W-1:0] k,
                                              input logic [RAW_W-1:0] raw,
                                              input logic [WHOLE_W-1:0] whole,
                                              input logic [FRAC_W-1:0] hund,
                                              input logic [QUERY_W-1:0] q);
        reading_t r;
        r.mode  = m;
        r.key   = k;
        r.raw   = raw;
        r.whole = whole;
        r.hund  = hund;
        r.query = q;
        return r;
    endfunction

    function automatic reading_t random_reading();
        reading_t r;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            r.mode = MODE_BUS;
        else if (pick < 55)
            r.mode = MODE_EXT;
        else if (pick < 68)
            r.mode = MODE_TICK;
        else if (pick < 77)
            r.mode = MODE_OSET;
        else if (pick < 85)
            r.mode = MODE_OCLR;
        else if (pick < 97)
            r.mode = MODE_READ;
        else
            r.mode = $urandom_range(0, 1) ? MODE_SPARE6 : MODE_SPARE7;
        r.key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                            : key_pool[$urandom_range(0, POOL_N - 1)];
        r.raw   = RAW_W'($urandom);
        r.whole = WHOLE_W'($urandom);
        r.hund  = ($urandom_range(0, 7) == 0) ? FRAC_W'($urandom) : FRAC_W'($urandom_range(0, 99));
        r.query = QUERY_W'($urandom);
        return r;
    endfunction

    task automatic send_item(input reading_t r);
        int           gap;
        slot_report_t rep;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            rd_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        rd_if.valid       <= 1'b1;
        rd_if.mode        <= r.mode;
        rd_if.sensor_key  <= r.key;
        rd_if.raw_reading <= r.raw;
        rd_if.whole_value <= r.whole;
        rd_if.hundredths  <= r.hund;
        rd_if.slot_query  <= r.query;
        do @(posedge clk); while (!rd_if.ready);
        rep = next_table_result(r);
        pending_results.push_back(rep);
        n_items++;
        mode_hits[r.mode]++;
        if (!rep.found && (r.mode == MODE_BUS || r.mode == MODE_EXT))
            full_hits++;
        if (rep.found && rep.missed == MISS_CAP)
            sat_hits++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        rd_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [MISS_W-1:0] v);
        drain_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        live_limit = v;
        n_limit_writes++;
    endtask

    task automatic test_directed();
        send_item(make_reading(MODE_READ, KEY_ZERO, '0, '0, '0, 4'd0));
        send_item(make_reading(MODE_READ, KEY_ONES, '0, '0, '0, 4'd15));
        send_item(make_reading(MODE_BUS, KEY_ONES, 16'h7FFF, '0, '0, '0));
        send_item(make_reading(MODE_BUS, KEY_ZERO, 16'h8000, '0, '0, '0));
        send_item(make_reading(MODE_BUS, KEY_A, 16'hFFFF, '0, '0, '0));
        send_item(make_reading(MODE_BUS, KEY_B, 16'h0000, 12'hFFF, 7'd127, 4'd15));
        send_item(make_reading(MODE_BUS, KEY_ONES, 16'hFFEF, '0, '0, '0));
        send_item(make_reading(MODE_EXT, KEY_E, '0, 12'h7FF, 7'd99, '0));
        send_item(make_reading(MODE_EXT, KEY_F, 16'hFFFF, 12'h800, 7'd0, '0));
        send_item(make_reading(MODE_EXT, KEY_G, '0, 12'hFFF, 7'd127, '0));
        send_item(make_reading(MODE_TICK, KEY_ONES, '0, '0, '0, '0));
        send_item(make_reading(MODE_OSET, KEY_A, '0, 12'hFFB, 7'd50, '0));
        // pinned slot: value and misses stay put
        send_item(make_reading(MODE_BUS, KEY_A, 16'h0064, '0, '0, '0));
        send_item(make_reading(MODE_OSET, KEY_GONE, '0, 12'h123, 7'd1, '0));
        send_item(make_reading(MODE_OCLR, KEY_GONE, '0, '0, '0, '0));
        send_item(make_reading(MODE_OCLR, KEY_B, '0, '0, '0, '0));
        // cleared key is still valid, so the lookup finds it again
        send_item(make_reading(MODE_BUS, KEY_B, 16'h0020, '0, '0, '0));
        send_item(make_reading(MODE_OCLR, KEY_B, '0, '0, '0, '0));
        send_item(make_reading(MODE_BUS, KEY_N, 16'hFF00, '0, '0, '0));
        send_item(make_reading(MODE_SPARE6, KEY_ONES, 16'hFFFF, 12'hFFF, 7'd127, 4'd15));
        send_item(make_reading(MODE_SPARE7, KEY_A, '0, '0, '0, 4'd3));
        send_item(make_reading(MODE_READ, KEY_ZERO, '0, '0, '0, 4'd3));
        send_item(make_reading(MODE_OCLR, KEY_A, '0, '0, '0, '0));
    endtask

    task automatic test_miss_saturation();
        write_limit(8'd255);
        send_item(make_reading(MODE_BUS, KEY_SAT, 16'h0190, '0, '0, '0));
        for (int i = 0; i < 252; i++)
        begin
            send_item(make_reading(MODE_TICK, {$urandom, $urandom}, RAW_W'($urandom), '0, '0, '0));
            if (i % 40 == 0)
                send_item(make_reading(MODE_READ, '0, '0, '0, '0, QUERY_W'(i / 40)));
        end
        for (int q = 0; q < SLOTS; q++)
            send_item(make_reading(MODE_READ, '0, '0, '0, '0, QUERY_W'(q)));
        write_limit(MISS_CAP);
        send_item(make_reading(MODE_READ, '0, '0, '0, '0, 4'd0));
        send_item(make_reading(MODE_BUS, KEY_ONES, 16'h0010, '0, '0, '0));
        write_limit(8'd0);
        send_item(make_reading(MODE_READ, '0, '0, '0, '0, 4'd0));
    endtask

    task automatic test_random_traffic();
        logic [MISS_W-1:0] lim;
        for (int i = 0; i < POOL_N; i++)
            key_pool[i] = {$urandom, $urandom};
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: lim = 8'd1;
                1: lim = 8'd255;
                2: lim = 8'd0;
                3: lim = MISS_LIMIT_RST;
                default: lim = MISS_W'($urandom);
            endcase
            write_limit(lim);
            steady = (phase == 3);
            // churn part of the pool so the table keeps filling and freeing
            repeat (4) key_pool[$urandom_range(0, POOL_N - 1)] = {$urandom, $urandom};
            for (int n = 0; n < 120; n++)
            begin
                send_item(random_reading());
                if ($urandom_range(0, 59) == 0)
                    drain_results();
            end
        end
        steady = 1'b0;
    endtask

    // result side: random stalls; no new stall starts during steady phases
    initial
    begin
        int stall;
        stall = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                res_if.ready <= 1'b0;
                stall--;
            end
            else
            begin
                res_if.ready <= 1'b1;
                if (!steady && $urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : check_beat
        slot_report_t got;
        slot_report_t want;
        string        diff;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got.slot    = res_if.slot;
            got.found   = res_if.slot_found;
            got.live    = res_if.live_count;
            got.has_val = res_if.entry_set;
            got.pinned  = res_if.entry_override;
            got.neg     = res_if.entry_negative;
            got.whole   = res_if.entry_whole;
            got.hund    = res_if.entry_hundredths;
            got.missed  = res_if.entry_missed;
            if (pending_results.size() == 0)
            begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %s", show(got));
            end
            else
            begin
                want = pending_results.pop_front();
                n_results++;
                diff = "";
                if (got.slot !== want.slot)       diff = {diff, " slot"};
                if (got.found !== want.found)     diff = {diff, " slot_found"};
                if (got.live !== want.live)       diff = {diff, " live_count"};
                if (got.has_val !== want.has_val) diff = {diff, " entry_set"};
                if (got.pinned !== want.pinned)   diff = {diff, " entry_override"};
                if (got.neg !== want.neg)         diff = {diff, " entry_negative"};
                if (got.whole !== want.whole)     diff = {diff, " entry_whole"};
                if (got.hund !== want.hund)       diff = {diff, " entry_hundredths"};
                if (got.missed !== want.missed)   diff = {diff, " entry_missed"};
                if (diff != "")
                begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d mismatch in%s\n  expected %s\n  actual   %s",
                                 n_results, diff, show(want), show(got));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        rd_if.valid       = 1'b0;
        rd_if.mode        = MODE_BUS;
        rd_if.sensor_key  = '0;
        rd_if.raw_reading = '0;
        rd_if.whole_value = '0;
        rd_if.hundredths  = '0;
        rd_if.slot_query  = '0;
        reset_model();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_miss_saturation();
        test_random_traffic();
        drain_results();

        $display("%0d commands (%0d bus, %0d external, %0d ticks, %0d override, %0d read), %0d results",
                 n_items, mode_hits[MODE_BUS], mode_hits[MODE_EXT], mode_hits[MODE_TICK],
                 mode_hits[MODE_OSET] + mode_hits[MODE_OCLR], mode_hits[MODE_READ], n_results);
        $display("%0d miss limit writes, %0d table-full readings, %0d saturated entries, %0d errors",
                 n_limit_writes, full_hits, sat_hits, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ files.f @@
rtl/srt_pkg.sv
rtl/srt_intf.sv
rtl/srt_ctrl.sv
rtl/srt_datapath.sv
rtl/sensor_reading_table.sv
dv/sensor_reading_table_tb.sv
